// ===== rtl/core/pps_pkg.sv =====
// ---------------------------------------------------------------------------
// Priority scheduler package
// Shared constants, codes and the per-cell command bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

  // Default sizing
  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths of the channel beats
  localparam int BURST_W = 8;
  localparam int PRIO_W  = 8;
  localparam int FTIME_W = 16;
  localparam int PID_W   = 4;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Update broadcast to the cell row; cmd_id selects the target cell
  typedef struct packed {
    logic               load;   // write a new process entry
    logic               run;    // run the entry for one slot
    logic [BURST_W-1:0] burst;  // burst of the new entry, never zero
    logic [PRIO_W-1:0]  prio;   // priority of the new entry
  } cell_cmd_t;

endpackage

// ===== rtl/core/pps_if.sv =====
// ---------------------------------------------------------------------------
// Priority scheduler channels
// Valid/ready interfaces for the item input and the result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [pps_pkg::BURST_W-1:0] burst;
  logic [pps_pkg::PRIO_W-1:0]  priority_req;
  logic [pps_pkg::FTIME_W-1:0] arrival;

  modport source (output valid, func, burst, priority_req, arrival, input ready);
  modport sink   (input valid, func, burst, priority_req, arrival, output ready);
endinterface

interface pps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        load_error;
  logic                        idle;
  logic [pps_pkg::PID_W-1:0]   proc_id;
  logic [pps_pkg::FTIME_W-1:0] slot_time;
  logic [pps_pkg::BURST_W-1:0] remaining;
  logic                        finished;
  logic [pps_pkg::FTIME_W-1:0] turnaround;
  logic [pps_pkg::FTIME_W-1:0] waiting;
  logic [pps_pkg::FTIME_W-1:0] response;

  modport source (output valid, load_error, idle, proc_id, slot_time, remaining,
                  finished, turnaround, waiting, response, input ready);
  modport sink   (input valid, load_error, idle, proc_id, slot_time, remaining,
                  finished, turnaround, waiting, response, output ready);
endinterface

// ===== rtl/core/pps_cell.sv =====
// ---------------------------------------------------------------------------
// Scheduler cell
// Holds one process entry and passes the best ready candidate so far
// (lowest priority number, earliest id on ties) to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_cell #(
  parameter int ID_W      = 4,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int CELL_ID   = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [TIME_BITS-1:0]       now,
  input  pps_pkg::cell_cmd_t         cmd,
  input  logic [ID_W-1:0]            cmd_id,
  input  logic [TIME_BITS-1:0]       cmd_time,
  input  logic                       cand_in_valid,
  input  logic [pps_pkg::PRIO_W-1:0] cand_in_prio,
  input  logic [ID_W-1:0]            cand_in_id,
  output logic                       cand_valid,
  output logic [pps_pkg::PRIO_W-1:0] cand_prio,
  output logic [ID_W-1:0]            cand_id,
  output logic [pps_pkg::BURST_W-1:0] rem_burst,
  output logic [pps_pkg::BURST_W-1:0] orig_burst,
  output logic [TIME_BITS-1:0]       arrive_time,
  output logic [TIME_BITS-1:0]       first_run,
  output logic                       started
);

  localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_ID);

  logic                       live;
  logic [pps_pkg::PRIO_W-1:0] prio;
  logic                       hit;
  logic                       ready_here;
  logic                       take;

  assign hit        = (cmd_id == MY_ID);
  assign ready_here = live && (arrive_time <= now);
  assign take       = ready_here && (!cand_in_valid || (prio < cand_in_prio));

  // Entry state: live and started are control, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= 1'b0;
      started <= 1'b0;
    end else if (cmd.load && hit) begin
      live    <= 1'b1;
      started <= 1'b0;
    end else if (cmd.run && hit) begin
      // last slot of the burst frees the entry
      if (rem_burst == pps_pkg::BURST_W'(1)) begin
        live    <= 1'b0;
        started <= 1'b0;
      end else begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      rem_burst   <= cmd.burst;
      orig_burst  <= cmd.burst;
      prio        <= cmd.prio;
      arrive_time <= cmd_time;
    end else if (cmd.run && hit) begin
      rem_burst <= rem_burst - pps_pkg::BURST_W'(1);
      if (!started) first_run <= now;
    end
  end

  // Candidate stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= cand_in_valid || ready_here;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_prio <= prio;
      cand_id   <= MY_ID;
    end else begin
      cand_prio <= cand_in_prio;
      cand_id   <= cand_in_id;
    end
  end

endmodule

// ===== rtl/core/preemptive_priority_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// Preemptive priority scheduler
// Process table as a row of cells; load beats add processes, tick beats
// run the best ready process for one slot and report its statistics.
// ---------------------------------------------------------------------------
// A load beat goes from the idle state straight to the commit state, where
// its result is registered. A tick beat passes through the scan state first,
// and its result is registered in the commit state because the winning
// candidate walks the cell row one cell per cycle before the slot is
// committed. The block handles one beat at a time; the result register lets
// the next beat be accepted while the previous result is still waiting on
// the output, and the commit of that next beat waits until the output is
// free. Ids count up from zero and are not reused until reset; proc_id
// carries the low four bits of the id.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);

  localparam int ID_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NID_W = $clog2(MAX_PROCS + 1);
  localparam int CNT_W = ID_W;
  localparam int BW    = pps_pkg::BURST_W;
  localparam int FW    = pps_pkg::FTIME_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t                     state;
  logic [CNT_W-1:0]           cnt;
  logic [NID_W-1:0]           next_id;
  logic [TIME_BITS-1:0]       now;

  // Latched item
  logic                       func_q;
  logic [BW-1:0]              burst_q;
  logic [pps_pkg::PRIO_W-1:0] prio_q;
  logic [TIME_BITS-1:0]       arrival_q;

  // Result register
  logic                       res_valid;
  logic                       res_load_error;
  logic                       res_idle;
  logic [pps_pkg::PID_W-1:0]  res_proc_id;
  logic [FW-1:0]              res_slot_time;
  logic [BW-1:0]              res_remaining;
  logic                       res_finished;
  logic [FW-1:0]              res_turnaround;
  logic [FW-1:0]              res_waiting;
  logic [FW-1:0]              res_response;

  // Cell row
  logic                       chain_valid [MAX_PROCS+1];
  logic [pps_pkg::PRIO_W-1:0] chain_prio  [MAX_PROCS+1];
  logic [ID_W-1:0]            chain_id    [MAX_PROCS+1];
  logic [BW-1:0]              rem_arr     [MAX_PROCS];
  logic [BW-1:0]              orig_arr    [MAX_PROCS];
  logic [TIME_BITS-1:0]       arrive_arr  [MAX_PROCS];
  logic [TIME_BITS-1:0]       first_arr   [MAX_PROCS];
  logic                       started_arr [MAX_PROCS];

  pps_pkg::cell_cmd_t         cmd;
  logic [ID_W-1:0]            cmd_id;

  logic                       in_fire;
  logic                       out_free;
  logic                       fin_go;
  logic                       full;

  // Winner and its statistics
  logic                       win_valid;
  logic [ID_W-1:0]            win_id;
  logic [BW-1:0]              rem_new;
  logic                       win_done;
  logic [TIME_BITS-1:0]       first_t;
  logic [TIME_BITS:0]         tt_full;
  logic [TIME_BITS-1:0]       tt;
  logic [TIME_BITS-1:0]       ob_ext;
  logic [TIME_BITS-1:0]       wait_t;
  logic [TIME_BITS-1:0]       resp_t;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !res_valid || out_ch.ready;
  assign fin_go      = (state == ST_FIN) && out_free;
  assign full        = (next_id >= NID_W'(MAX_PROCS));

  // Head of the row sees no candidate
  assign chain_valid[0] = 1'b0;
  assign chain_prio[0]  = '0;
  assign chain_id[0]    = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    pps_cell #(
      .ID_W      (ID_W),
      .TIME_BITS (TIME_BITS),
      .CELL_ID   (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .now           (now),
      .cmd           (cmd),
      .cmd_id        (cmd_id),
      .cmd_time      (arrival_q),
      .cand_in_valid (chain_valid[g]),
      .cand_in_prio  (chain_prio[g]),
      .cand_in_id    (chain_id[g]),
      .cand_valid    (chain_valid[g+1]),
      .cand_prio     (chain_prio[g+1]),
      .cand_id       (chain_id[g+1]),
      .rem_burst     (rem_arr[g]),
      .orig_burst    (orig_arr[g]),
      .arrive_time   (arrive_arr[g]),
      .first_run     (first_arr[g]),
      .started       (started_arr[g])
    );
  end

  // Winner statistics for the slot being committed
  assign win_valid = chain_valid[MAX_PROCS];
  assign win_id    = chain_id[MAX_PROCS];
  assign rem_new   = rem_arr[win_id] - BW'(1);
  assign win_done  = (rem_new == '0);
  assign first_t   = started_arr[win_id] ? first_arr[win_id] : now;
  assign tt_full   = {1'b0, now} + (TIME_BITS+1)'(1) - {1'b0, arrive_arr[win_id]};
  assign tt        = tt_full[TIME_BITS] ? TIME_MAX : tt_full[TIME_BITS-1:0];
  assign ob_ext    = TIME_BITS'(orig_arr[win_id]);
  assign wait_t    = (tt >= ob_ext) ? (tt - ob_ext) : '0;
  assign resp_t    = first_t - arrive_arr[win_id];

  // Commit broadcast to the cells
  always_comb begin
    cmd.load  = fin_go && (func_q == pps_pkg::FUNC_LOAD) && !full;
    cmd.run   = fin_go && (func_q == pps_pkg::FUNC_TICK) && win_valid;
    cmd.burst = (burst_q == '0) ? BW'(1) : burst_q;
    cmd.prio  = prio_q;
    cmd_id    = (func_q == pps_pkg::FUNC_LOAD) ? next_id[ID_W-1:0] : win_id;
  end

  // Sequencer, time, id counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      next_id   <= '0;
      now       <= '0;
      res_valid <= 1'b0;
    end else begin
      // result beat: set on commit, cleared when taken
      if (fin_go) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_fire) begin
            state <= (in_ch.func == pps_pkg::FUNC_TICK) ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_PROCS - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (func_q == pps_pkg::FUNC_LOAD) begin
              if (!full) next_id <= next_id + NID_W'(1);
            end else if (now != TIME_MAX) begin
              now <= now + TIME_BITS'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_q    <= in_ch.func;
      burst_q   <= in_ch.burst;
      prio_q    <= in_ch.priority_req;
      arrival_q <= TIME_BITS'(in_ch.arrival);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_load_error <= 1'b0;
      res_idle       <= 1'b0;
      res_proc_id    <= '0;
      res_slot_time  <= '0;
      res_remaining  <= '0;
      res_finished   <= 1'b0;
      res_turnaround <= '0;
      res_waiting    <= '0;
      res_response   <= '0;
      if (func_q == pps_pkg::FUNC_LOAD) begin
        if (full) res_load_error <= 1'b1;
        else      res_proc_id    <= pps_pkg::PID_W'(next_id);
      end else begin
        res_slot_time <= FW'(now);
        if (!win_valid) begin
          res_idle <= 1'b1;
        end else begin
          res_proc_id   <= pps_pkg::PID_W'(win_id);
          res_remaining <= rem_new;
          if (win_done) begin
            res_finished   <= 1'b1;
            res_turnaround <= FW'(tt);
            res_waiting    <= FW'(wait_t);
            res_response   <= FW'(resp_t);
          end
        end
      end
    end
  end

  assign out_ch.valid      = res_valid;
  assign out_ch.load_error = res_load_error;
  assign out_ch.idle       = res_idle;
  assign out_ch.proc_id    = res_proc_id;
  assign out_ch.slot_time  = res_slot_time;
  assign out_ch.remaining  = res_remaining;
  assign out_ch.finished   = res_finished;
  assign out_ch.turnaround = res_turnaround;
  assign out_ch.waiting    = res_waiting;
  assign out_ch.response   = res_response;

  // Checks
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_FIN))
    else $error("result beat appeared without a commit");

  a_idle_not_finished: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_idle && res_finished))
    else $error("idle tick reported a finished process");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.run))
    else $error("load and run committed together");

  a_id_bound: assert property (@(posedge clk) disable iff (rst)
    next_id <= NID_W'(MAX_PROCS))
    else $error("id counter ran past the table size");

endmodule
